FILE: rtl/core/mtavt_pkg.sv
// Shared types and constants for the multi-turn angle and velocity tracker.
package mtavt_pkg;

    localparam int THR_W      = 12;
    localparam int TIME_W     = 32;
    localparam int TURN_W     = 16;
    localparam int FB_W       = 16;
    localparam int VEL_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_INTERVAL = 2'd2;

    localparam logic [THR_W-1:0]  RST_WRAP_THRESHOLD    = 12'd3277;
    localparam logic [TIME_W-1:0] RST_MAX_INTERVAL      = 32'd100000;
    localparam logic [FB_W-1:0]   RST_FALLBACK_INTERVAL = 16'd10;

    localparam int               MICROS_W     = 20;
    localparam logic [MICROS_W-1:0] MICROS_PER_S = 20'd1000000;

    localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [THR_W-1:0]  wrap_threshold;
        logic [TIME_W-1:0] max_interval_us;
        logic [FB_W-1:0]   fallback_interval_us;
    } t_cfg;

endpackage

FILE: rtl/core/multi_turn_angle_velocity_tracker.sv
// Multi-turn angle tracker with velocity estimate: top level, config registers, checks.
// Each input beat is a sample (action 0) or a velocity request (action 1) and gives
// one result beat. The front part unwraps sample angles into a signed turn count in
// the cycle the beat is taken and queues a snapshot (four entries); it stalls only
// when that queue is full. The back part answers a sample by loading the output
// register when free; a request runs: form the count change, multiply by
// 10^6, range check, 32 steps of a restoring divider (skipped on overflow), then
// saturate and load the output register. The result holds the angle and turn
// count after the beat and, for requests, the velocity in counts per second,
// truncated toward zero and saturated to 32 bits. The user must write registers
// through i_cfg_we / i_cfg_index / i_cfg_data only while idle; it is not enforced.
module multi_turn_angle_velocity_tracker #(
    parameter int COUNTS_PER_TURN_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mtavt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mtavt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_action,
    input  logic [COUNTS_PER_TURN_BITS-1:0]     i_raw_angle,
    input  logic [mtavt_pkg::TIME_W-1:0]        i_timestamp_us,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [COUNTS_PER_TURN_BITS-1:0]     o_angle_count,
    output logic signed [mtavt_pkg::TURN_W-1:0] o_turn_count,
    output logic signed [mtavt_pkg::VEL_W-1:0]  o_velocity,
    output logic                                o_velocity_valid
);
    localparam int ANG_W = COUNTS_PER_TURN_BITS;
    localparam int ENT_W = 1 + ANG_W + mtavt_pkg::TURN_W + mtavt_pkg::TIME_W;

    mtavt_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrap_threshold       <= mtavt_pkg::RST_WRAP_THRESHOLD;
            r_cfg.max_interval_us      <= mtavt_pkg::RST_MAX_INTERVAL;
            r_cfg.fallback_interval_us <= mtavt_pkg::RST_FALLBACK_INTERVAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mtavt_pkg::CFG_WRAP_THRESHOLD: begin
                    r_cfg.wrap_threshold <= i_cfg_data[mtavt_pkg::THR_W-1:0];
                end
                mtavt_pkg::CFG_MAX_INTERVAL: begin
                    r_cfg.max_interval_us <= i_cfg_data[mtavt_pkg::TIME_W-1:0];
                end
                mtavt_pkg::CFG_FALLBACK_INTERVAL: begin
                    r_cfg.fallback_interval_us <= i_cfg_data[mtavt_pkg::FB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    logic             w_push;
    logic             w_pop;
    logic             w_q_full;
    logic             w_q_empty;
    logic [ENT_W-1:0] w_push_entry;
    logic [ENT_W-1:0] w_head;
    logic [mtavt_pkg::TURN_W-1:0] w_turns;
    logic [mtavt_pkg::VEL_W-1:0]  w_vel;

    mtavt_front #(
        .ANG_W (ANG_W),
        .ENT_W (ENT_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_in_valid),
        .i_action       (i_action),
        .i_raw_angle    (i_raw_angle),
        .i_timestamp_us (i_timestamp_us),
        .i_q_full       (w_q_full),
        .o_stall        (o_in_stall),
        .o_push         (w_push),
        .o_entry        (w_push_entry)
    );

    mtavt_fifo #(
        .W     (ENT_W),
        .DEPTH (mtavt_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    mtavt_back #(
        .ANG_W (ANG_W),
        .ENT_W (ENT_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_empty        (w_q_empty),
        .i_q_head         (w_head),
        .o_pop            (w_pop),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_angle_count    (o_angle_count),
        .o_turn_count     (w_turns),
        .o_velocity       (w_vel),
        .o_velocity_valid (o_velocity_valid)
    );

    assign o_turn_count = signed'(w_turns);
    assign o_velocity   = signed'(w_vel);

`ifndef ASSERT_OFF
    // sample results never carry a velocity
    a_sample_vel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_velocity_valid) |-> (o_velocity == '0))
        else $error("sample result with nonzero velocity");

    // no result beat may appear right after reset
    a_no_out_after_rst: assert property (@(posedge i_clk)
        (!i_rst_n) |=> !o_out_valid)
        else $error("result valid right after reset");

    // the back part never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("queue popped while empty");
`endif

endmodule

FILE: rtl/core/mtavt_fifo.sv
// Small register queue between the front and back parts.
module mtavt_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_head,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/mtavt_front.sv
// Front part: accepts beats, unwraps sample angles into turns, queues snapshots.
module mtavt_front #(
    parameter int ANG_W = 12,
    parameter int ENT_W = 1 + ANG_W + mtavt_pkg::TURN_W + mtavt_pkg::TIME_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mtavt_pkg::t_cfg               i_cfg,
    input  logic                          i_valid,
    input  logic                          i_action,
    input  logic [ANG_W-1:0]              i_raw_angle,
    input  logic [mtavt_pkg::TIME_W-1:0]  i_timestamp_us,
    input  logic                          i_q_full,
    output logic                          o_stall,
    output logic                          o_push,
    output logic [ENT_W-1:0]              o_entry
);
    localparam int CW = ANG_W + 14;

    logic [ANG_W-1:0]             r_last_angle;
    logic [mtavt_pkg::TURN_W-1:0] r_turns;
    logic [mtavt_pkg::TIME_W-1:0] r_last_time;
    logic [mtavt_pkg::TURN_W-1:0] n_turns;

    logic signed [CW-1:0] w_diff;
    logic signed [CW-1:0] w_thr;
    logic                 w_acc;

    assign o_stall = i_q_full;
    assign w_acc   = i_valid && !i_q_full;
    assign o_push  = w_acc;

    assign w_diff = signed'(CW'(i_raw_angle)) - signed'(CW'(r_last_angle));
    assign w_thr  = signed'(CW'(i_cfg.wrap_threshold));

    // jump forward past the threshold means we crossed zero backwards
    always_comb begin
        n_turns = r_turns;
        if (w_diff > w_thr) begin
            n_turns = r_turns - 1'b1;
        end else if (w_diff < -w_thr) begin
            n_turns = r_turns + 1'b1;
        end
    end

    // entry: {time, turns, angle, action}; requests carry the pre-request state
    always_comb begin
        if (i_action) begin
            o_entry = {r_last_time, r_turns, r_last_angle, 1'b1};
        end else begin
            o_entry = {i_timestamp_us, n_turns, i_raw_angle, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_angle <= '0;
            r_turns      <= '0;
            r_last_time  <= '0;
        end else if (w_acc && !i_action) begin
            r_last_angle <= i_raw_angle;
            r_turns      <= n_turns;
            r_last_time  <= i_timestamp_us;
        end
    end

endmodule

FILE: rtl/core/mtavt_back.sv
// Back part: emits sample results and runs the velocity divide for requests.
module mtavt_back #(
    parameter int ANG_W = 12,
    parameter int ENT_W = 1 + ANG_W + mtavt_pkg::TURN_W + mtavt_pkg::TIME_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mtavt_pkg::t_cfg               i_cfg,
    input  logic                          i_q_empty,
    input  logic [ENT_W-1:0]              i_q_head,
    output logic                          o_pop,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [ANG_W-1:0]              o_angle_count,
    output logic [mtavt_pkg::TURN_W-1:0]  o_turn_count,
    output logic [mtavt_pkg::VEL_W-1:0]   o_velocity,
    output logic                          o_velocity_valid
);
    localparam int TURN_W  = mtavt_pkg::TURN_W;
    localparam int TIME_W  = mtavt_pkg::TIME_W;
    localparam int VEL_W   = mtavt_pkg::VEL_W;
    localparam int DELTA_W = ANG_W + 17;
    localparam int MAG_W   = ANG_W + 16;
    localparam int DVD_W   = MAG_W + mtavt_pkg::MICROS_W;
    localparam int QB      = 32;
    localparam int HI_W    = DVD_W - QB;
    localparam int CNT_W   = $clog2(QB);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // head entry fields
    logic                h_action;
    logic [ANG_W-1:0]    h_angle;
    logic [TURN_W-1:0]   h_turns;
    logic [TIME_W-1:0]   h_time;

    assign h_action = i_q_head[0];
    assign h_angle  = i_q_head[ANG_W:1];
    assign h_turns  = i_q_head[ANG_W+TURN_W:ANG_W+1];
    assign h_time   = i_q_head[ENT_W-1:ANG_W+TURN_W+1];

    logic [2:0]          r_state, n_state;
    logic [ANG_W-1:0]    r_ref_angle;
    logic [TURN_W-1:0]   r_ref_turns;
    logic [TIME_W-1:0]   r_ref_time;
    logic                r_out_valid;

    logic [ANG_W-1:0]    r_res_angle;
    logic [TURN_W-1:0]   r_res_turns;
    logic                r_neg;
    logic                r_ovf;
    logic [MAG_W-1:0]    r_mag;
    logic [TIME_W-1:0]   r_elapsed;
    logic [DVD_W-1:0]    r_dvd;
    logic [QB-1:0]       r_div;
    logic [QB-1:0]       r_rem;
    logic [QB-1:0]       r_q;
    logic [CNT_W-1:0]    r_cnt;

    logic [ANG_W-1:0]    r_out_angle;
    logic [TURN_W-1:0]   r_out_turns;
    logic [VEL_W-1:0]    r_out_vel;
    logic                r_out_vv;

    // delta since the reference point
    logic signed [TURN_W-1:0]  w_dturn;
    logic signed [DELTA_W-1:0] w_delta;
    logic signed [DELTA_W-1:0] w_delta_abs;

    assign w_dturn     = signed'(h_turns - r_ref_turns);
    assign w_delta     = (DELTA_W'(w_dturn) <<< ANG_W)
                       + (signed'(DELTA_W'(h_angle)) - signed'(DELTA_W'(r_ref_angle)));
    assign w_delta_abs = w_delta[DELTA_W-1] ? -w_delta : w_delta;

    // interval selection
    logic [QB-1:0] w_fb;
    logic [QB-1:0] w_intv;

    assign w_fb   = (i_cfg.fallback_interval_us == '0) ? QB'(1)
                                                       : QB'(i_cfg.fallback_interval_us);
    assign w_intv = (r_elapsed == '0 || r_elapsed > i_cfg.max_interval_us) ? w_fb
                                                                           : r_elapsed;

    // quotient only fits in 32 bits when the upper dividend part is below the divisor
    logic [HI_W-1:0] w_hi;
    logic            w_big;

    assign w_hi  = r_dvd[DVD_W-1:QB];
    assign w_big = (QB'(w_hi) >= r_div);

    // one restoring step
    logic [QB:0] w_rem_sh;
    logic [QB:0] w_sub;
    logic        w_ge;

    assign w_rem_sh = {r_rem, r_q[QB-1]};
    assign w_sub    = w_rem_sh - {1'b0, r_div};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});

    // saturate into signed 32 bits
    logic [VEL_W-1:0] w_vel;

    always_comb begin
        if (r_ovf) begin
            w_vel = r_neg ? mtavt_pkg::VEL_MIN : mtavt_pkg::VEL_MAX;
        end else if (!r_neg) begin
            w_vel = r_q[QB-1] ? mtavt_pkg::VEL_MAX : r_q;
        end else begin
            w_vel = (r_q > mtavt_pkg::VEL_MIN) ? mtavt_pkg::VEL_MIN : (~r_q + 1'b1);
        end
    end

    logic w_out_free;
    logic w_load;
    logic w_load_vel;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_load     = 1'b0;
        w_load_vel = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    if (!h_action) begin
                        if (w_out_free) begin
                            o_pop  = 1'b1;
                            w_load = 1'b1;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                n_state = w_big ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(QB - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_load     = 1'b1;
                    w_load_vel = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ref_angle <= '0;
            r_ref_turns <= '0;
            r_ref_time  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && o_pop && h_action) begin
                r_ref_angle <= h_angle;
                r_ref_turns <= h_turns;
                r_ref_time  <= h_time;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && o_pop && h_action) begin
            r_res_angle <= h_angle;
            r_res_turns <= h_turns;
            r_neg       <= w_delta[DELTA_W-1];
            r_mag       <= w_delta_abs[MAG_W-1:0];
            r_elapsed   <= h_time - r_ref_time;
        end
        if (r_state == ST_MUL) begin
            r_dvd <= DVD_W'(r_mag) * DVD_W'(mtavt_pkg::MICROS_PER_S);
            r_div <= w_intv;
        end
        if (r_state == ST_CHK) begin
            r_ovf <= w_big;
            r_rem <= QB'(w_hi);
            r_q   <= r_dvd[QB-1:0];
            r_cnt <= '0;
        end
        if (r_state == ST_DIV) begin
            r_rem <= w_ge ? w_sub[QB-1:0] : w_rem_sh[QB-1:0];
            r_q   <= {r_q[QB-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (w_load) begin
            r_out_angle <= w_load_vel ? r_res_angle : h_angle;
            r_out_turns <= w_load_vel ? r_res_turns : h_turns;
            r_out_vel   <= w_load_vel ? w_vel : '0;
            r_out_vv    <= w_load_vel;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_angle_count    = r_out_angle;
    assign o_turn_count     = r_out_turns;
    assign o_velocity       = r_out_vel;
    assign o_velocity_valid = r_out_vv;

endmodule
